// ===== hw/rtl/sm4ke_pkg.sv =====
// SM4 key expansion: shared types, constants and round helper functions.
// No dependencies; imported by every module of the key expansion block.
package sm4ke_pkg;

    localparam logic [7:0] KEY_LEN_BYTES = 8'd16;
    localparam int unsigned ROUNDS = 32;
    localparam int unsigned ROUND_W = 5;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 5'd31;

    // System parameter FK
    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    // One classified key, FK already applied
    typedef struct packed {
        logic        err;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } key_entry_t;

    localparam logic [7:0] SBOX_TABLE [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_TABLE[x];
    endfunction

    // CK byte j of round r is 7*(4r+j) mod 256
    function automatic logic [31:0] round_const(input logic [ROUND_W-1:0] r);
        logic [31:0] w;
        logic [7:0]  idx;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            idx = {1'b0, r, 2'(j)};
            w = {w[23:0], 8'(idx * 8'd7)};
        end
        return w;
    endfunction

    // Byte substitution followed by L'(b) = b ^ rotl(b,13) ^ rotl(b,23)
    function automatic logic [31:0] key_mix(input logic [31:0] x);
        logic [31:0] b;
        b = {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

endpackage

// ===== hw/rtl/sm4_key_expansion.sv =====
// SM4 key expansion top level: front end, key queue and round engine.
// Depends on sm4ke_pkg, sm4ke_front, sm4ke_fifo and sm4ke_round.
//
// Usage:
//   Key channel (key_valid / key_stall): one transfer carries a 128-bit key
//   as key_high/key_low, byte 0 in the top bits of key_high, plus key_bytes.
//   Round key channel (rk_valid / rk_stall): a good key (key_bytes == 16)
//   gives 32 transfers, round_index 0..31, last set on index 31. Any other
//   length gives a single transfer with round_key 0, index 0, last and
//   key_error set.
// Path: a key passes the front register, the queue, the round state and the
//   output register before rk_valid rises; a full queue or a busy engine delays it.
// Rounds: one round per cycle while the output is not stalled, from a single
//   shared round unit (four S-box lookups plus the L' mix); a rejected key
//   ends at its first round step.
// The front end and a QUEUE_DEPTH-entry queue keep taking keys while the
//   round engine works, so key_stall rises only when the queue is full.
// Stall: while rk_stall is high the output register holds its transfer and, once
//   that register is full, the round engine pauses; nothing is dropped.
// Reset: rst_n clears the queue, the engine and both valids at once.
module sm4_key_expansion
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_stall,
    input  logic [63:0] key_high,
    input  logic [63:0] key_low,
    input  logic [7:0]  key_bytes,
    output logic        rk_valid,
    input  logic        rk_stall,
    output logic [31:0] round_key,
    output logic [4:0]  round_index,
    output logic        last,
    output logic        key_error
);
    import sm4ke_pkg::*;

    key_entry_t push_entry;
    key_entry_t pop_entry;
    logic       push_valid;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;

    // Length check and FK whitening
    sm4ke_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key_high   (key_high),
        .key_low    (key_low),
        .key_bytes  (key_bytes),
        .push_valid (push_valid),
        .push_full  (q_full),
        .push_entry (push_entry)
    );

    // Decouples key intake from the round engine
    sm4ke_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .pop_entry  (pop_entry)
    );

    // Next key loads in the same cycle the last round issues
    sm4ke_round u_round
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .rk_valid    (rk_valid),
        .rk_stall    (rk_stall),
        .round_key   (round_key),
        .round_index (round_index),
        .last        (last),
        .key_error   (key_error)
    );

endmodule

// ===== hw/rtl/sm4ke_front.sv =====
// SM4 key expansion front end: registers the incoming key, checks its length
// and applies FK. Depends on sm4ke_pkg.
module sm4ke_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  key_valid,
    output logic                  key_stall,
    input  logic [63:0]           key_high,
    input  logic [63:0]           key_low,
    input  logic [7:0]            key_bytes,
    output logic                  push_valid,
    input  logic                  push_full,
    output sm4ke_pkg::key_entry_t push_entry
);
    import sm4ke_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    key_entry_t entry_reg;
    logic       take;

    assign key_stall  = valid_reg && push_full;
    assign take       = key_valid && !key_stall;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (!push_full)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg.err <= (key_bytes != KEY_LEN_BYTES);
            entry_reg.w0  <= key_high[63:32] ^ FK0;
            entry_reg.w1  <= key_high[31:0]  ^ FK1;
            entry_reg.w2  <= key_low[63:32]  ^ FK2;
            entry_reg.w3  <= key_low[31:0]   ^ FK3;
        end
    end

endmodule

// ===== hw/rtl/sm4ke_fifo.sv =====
// SM4 key expansion: short queue of classified keys between front and back.
// Depends on sm4ke_pkg for the entry type.
module sm4ke_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sm4ke_pkg::key_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output sm4ke_pkg::key_entry_t pop_entry
);
    import sm4ke_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    key_entry_t       mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== hw/rtl/sm4ke_round.sv =====
// SM4 key expansion back end: one key schedule round per cycle into a
// registered output stage, unless rk_stall holds that stage full. Depends on sm4ke_pkg.
module sm4ke_round
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  sm4ke_pkg::key_entry_t q_entry,
    output logic                  q_pop,
    output logic                  rk_valid,
    input  logic                  rk_stall,
    output logic [31:0]           round_key,
    output logic [4:0]            round_index,
    output logic                  last,
    output logic                  key_error
);
    import sm4ke_pkg::*;

    logic               busy_reg;
    logic               busy_next;
    logic               err_reg;
    logic [ROUND_W-1:0] cnt_reg;
    logic [31:0]        w0_reg;
    logic [31:0]        w1_reg;
    logic [31:0]        w2_reg;
    logic [31:0]        w3_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        key_reg;
    logic [4:0]         index_reg;
    logic               last_reg;
    logic               error_reg;
    logic               advance;
    logic               finishing;
    logic               load;
    logic [31:0]        rk;

    assign advance   = busy_reg && (!out_valid_reg || !rk_stall);
    assign finishing = advance && (err_reg || cnt_reg == LAST_ROUND);
    assign load      = q_valid && (!busy_reg || finishing);
    assign q_pop     = load;

    assign rk = w0_reg ^ key_mix(w1_reg ^ w2_reg ^ w3_reg ^ round_const(cnt_reg));

    assign rk_valid    = out_valid_reg;
    assign round_key   = key_reg;
    assign round_index = index_reg;
    assign last        = last_reg;
    assign key_error   = error_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (load)
            busy_next = 1'b1;
        else if (finishing)
            busy_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!rk_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Round state and output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg <= q_entry.err;
            cnt_reg <= '0;
            w0_reg  <= q_entry.w0;
            w1_reg  <= q_entry.w1;
            w2_reg  <= q_entry.w2;
            w3_reg  <= q_entry.w3;
        end
        else if (advance)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            w0_reg  <= w1_reg;
            w1_reg  <= w2_reg;
            w2_reg  <= w3_reg;
            w3_reg  <= rk;
        end

        if (advance)
        begin
            key_reg   <= err_reg ? '0 : rk;
            index_reg <= err_reg ? '0 : cnt_reg;
            last_reg  <= err_reg || (cnt_reg == LAST_ROUND);
            error_reg <= err_reg;
        end
    end

endmodule
